### hdl/bia_pkg.sv
// Shared codes, defaults and width helpers for the bitmap index allocator.
package bia_pkg;

  // Default geometry
  localparam int INDEX_BITS_DEF = 12;
  localparam int WORD_BITS_DEF  = 32;

  // Item kinds (carried on in_tuser)
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_WR_LOCAL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_GLOBAL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WR_VALID  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_AL_LOCAL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_AL_GLOBAL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TRAVERSE  = 3'd5;

  // Result status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MAX  = 1'b1;

  // Round a bit count up to whole bytes
  function automatic int bytes_up(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

### hdl/bia_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/bitmap_index_allocator_top.sv
// Bitmap index allocator: three bitmap RAMs, a shared reciprocal divider and a word scanner.
// Flow: checks, early traverse misses, unused kinds: S_IDLE then S_FIN; bit writes: S_DIV,
//   S_OFF, S_WRD, S_WRM; searches: S_DIV, S_OFF, S_SCAN over at most MAP_WORDS words.
// Throughput: one transaction at a time, the next taken once the result is in the output
//   register; one word read per cycle from each bitmap RAM sets the search time.
// Reset: synchronous, active low; a clearing pass over MAP_WORDS words (128 at defaults)
//   zeroes all maps, in_tready low meanwhile; config writes are taken in every state.
module bitmap_index_allocator_top #(
  parameter int INDEX_BITS = bia_pkg::INDEX_BITS_DEF,
  parameter int WORD_BITS  = bia_pkg::WORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input channel
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // tdata: index, index_absent, bit_value, traverse_start (from bit 0 up)
  input  logic [bia_pkg::bytes_up(INDEX_BITS+3)-1:0] in_tdata,
  // tuser: kind
  input  logic [bia_pkg::KIND_W-1:0]                 in_tuser,
  // result channel
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // tdata: result_index, status (from bit 0 up)
  output logic [bia_pkg::bytes_up(INDEX_BITS+2)-1:0] out_tdata,
  // configuration
  input  logic                                       cfg_we,
  input  logic [bia_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [INDEX_BITS-1:0]                      cfg_wdata
);
  import bia_pkg::*;

  localparam int ENTRY_COUNT = 1 << INDEX_BITS;
  localparam int MAP_WORDS   = (ENTRY_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int POS_W       = (INDEX_BITS > BIT_W ? INDEX_BITS : BIT_W) + 2;
  localparam int OUT_W       = bytes_up(INDEX_BITS + 2);
  // word address = (index * RECIP) >> SH_W, exact for every index
  localparam int     SH_W    = INDEX_BITS + BIT_W;
  localparam int     RECIP_W = INDEX_BITS + 1;
  localparam int     PROD_W  = INDEX_BITS + RECIP_W;
  localparam longint RECIP   = ((longint'(1) << SH_W) + longint'(WORD_BITS) - 1) /
                               longint'(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_WRM  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OFF  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [WADDR_W-1:0]    word_r, word_nxt;
  logic [POS_W-1:0]      base_r, base_nxt;
  logic [POS_W-1:0]      start_r, start_nxt;
  logic [POS_W-1:0]      limit_r, limit_nxt;
  logic                  first_r, first_nxt;
  logic                  dv_r, dv_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic                  bitv_r, bitv_nxt;
  logic [INDEX_BITS-1:0] div_num_r, div_num_nxt;
  logic [BIT_W-1:0]      div_rem_r, div_rem_nxt;
  logic [INDEX_BITS-1:0] res_r, res_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;
  logic [INDEX_BITS-1:0] alloc_mask_r, index_max_r;

  // input fields
  logic [INDEX_BITS-1:0] in_idx;
  logic                  in_absent, in_bitv, in_tstart;
  logic [POS_W-1:0]      trav_start;

  // RAM ports
  logic                  we_loc, we_glob, we_val;
  word_t                 wr_data, rd_loc, rd_glob, rd_val;

  // shared reciprocal divider
  logic [PROD_W-1:0]     prod;
  logic [WADDR_W-1:0]    quot;
  logic [POS_W-1:0]      word_base, off_full;

  // scanner
  logic [POS_W-1:0]      hi_off;
  logic                  last_w;
  logic [BIT_W-1:0]      lo_off;
  word_t                 cand, win, hit_vec, iso, bit_sel, wr_src;
  logic                  hit;
  logic [BIT_W-1:0]      enc;

  assign in_idx     = in_tdata[INDEX_BITS-1:0];
  assign in_absent  = in_tdata[INDEX_BITS];
  assign in_bitv    = in_tdata[INDEX_BITS+1];
  assign in_tstart  = in_tdata[INDEX_BITS+2];
  assign trav_start = POS_W'(in_idx) + POS_W'(!in_tstart);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // word address by reciprocal multiply, then bit offset from the word base
  assign prod      = PROD_W'(div_num_r) * PROD_W'(RECIP);
  assign quot      = WADDR_W'(prod >> SH_W);
  assign word_base = POS_W'(word_r) * POS_W'(WORD_BITS);
  assign off_full  = start_r - word_base;

  // window of the current word that lies inside [start, limit]
  assign hi_off = limit_r - base_r;
  assign last_w = (hi_off < POS_W'(WORD_BITS));
  assign lo_off = first_r ? div_rem_r : '0;

  always_comb begin
    unique case (kind_r)
      KIND_TRAVERSE:  cand = rd_loc;
      KIND_AL_GLOBAL: cand = rd_val & ~rd_glob;
      default:        cand = rd_val & ~rd_loc;
    endcase
  end

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      win[b]     = (BIT_W'(b) >= lo_off) && (!last_w || (POS_W'(b) <= hi_off));
      bit_sel[b] = (BIT_W'(b) == div_rem_r);
    end
  end

  assign hit_vec = cand & win;
  assign hit     = |hit_vec;
  // isolate lowest set bit, then encode it
  assign iso     = hit_vec & (~hit_vec + word_t'(1));

  always_comb begin
    enc = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (((b >> k) & 1) == 1) begin
          enc[k] = enc[k] | iso[b];
        end
      end
    end
  end

  // read-modify-write source word for bit writes
  always_comb begin
    unique case (kind_r)
      KIND_WR_GLOBAL: wr_src = rd_glob;
      KIND_WR_VALID:  wr_src = rd_val;
      default:        wr_src = rd_loc;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    start_nxt     = start_r;
    limit_nxt     = limit_r;
    first_nxt     = first_r;
    dv_nxt        = dv_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    bitv_nxt      = bitv_r;
    div_num_nxt   = div_num_r;
    div_rem_nxt   = div_rem_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    we_loc        = 1'b0;
    we_glob       = 1'b0;
    we_val        = 1'b0;
    wr_data       = bitv_r ? (wr_src | bit_sel) : (wr_src & ~bit_sel);

    // output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // zero all maps after reset
      S_CLR: begin
        wr_data  = '0;
        we_loc   = 1'b1;
        we_glob  = 1'b1;
        we_val   = 1'b1;
        word_nxt = word_r + 1'b1;
        if (word_r == WADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // take a transaction and decode it
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = in_tuser;
          idx_nxt     = in_idx;
          bitv_nxt    = in_bitv;
          start_nxt   = POS_W'(in_idx);
          div_num_nxt = in_idx;
          div_rem_nxt = '0;
          res_nxt     = '0;
          status_nxt  = ST_OK;
          state_nxt   = S_FIN;
          unique case (in_tuser)
            KIND_WR_LOCAL, KIND_WR_GLOBAL, KIND_WR_VALID: begin
              state_nxt = S_DIV;
            end
            KIND_AL_LOCAL, KIND_AL_GLOBAL: begin
              if (in_absent) begin
                limit_nxt = POS_W'((in_idx & ~alloc_mask_r) | alloc_mask_r);
                state_nxt = S_DIV;
              end else if (in_idx > index_max_r) begin
                status_nxt = ST_BEYOND;
              end else begin
                res_nxt = in_idx;
              end
            end
            KIND_TRAVERSE: begin
              limit_nxt = POS_W'(index_max_r);
              if (trav_start > POS_W'(index_max_r)) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                start_nxt   = trav_start;
                div_num_nxt = trav_start[INDEX_BITS-1:0];
                state_nxt   = S_DIV;
              end
            end
            default: begin
              // unused kinds: zero result, ok
            end
          endcase
        end
      end

      // word address of the start index
      S_DIV: begin
        word_nxt  = quot;
        state_nxt = S_OFF;
      end

      // word base and bit offset of the start index
      S_OFF: begin
        base_nxt    = word_base;
        div_rem_nxt = off_full[BIT_W-1:0];
        first_nxt   = 1'b1;
        dv_nxt      = 1'b0;
        if (kind_r == KIND_WR_LOCAL || kind_r == KIND_WR_GLOBAL ||
            kind_r == KIND_WR_VALID) begin
          state_nxt = S_WRD;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      // read issued at word_r
      S_WRD: begin
        state_nxt = S_WRM;
      end

      // modify one bit and write back
      S_WRM: begin
        we_loc     = (kind_r == KIND_WR_LOCAL);
        we_glob    = (kind_r == KIND_WR_GLOBAL);
        we_val     = (kind_r == KIND_WR_VALID);
        res_nxt    = idx_r;
        status_nxt = ST_OK;
        state_nxt  = S_FIN;
      end

      // reads run one word ahead of evaluation
      S_SCAN: begin
        word_nxt = word_r + 1'b1;
        dv_nxt   = 1'b1;
        if (dv_r) begin
          if (hit) begin
            res_nxt    = INDEX_BITS'(base_r + POS_W'(enc));
            status_nxt = ST_OK;
            state_nxt  = S_FIN;
          end else if (last_w) begin
            res_nxt    = '0;
            status_nxt = (kind_r == KIND_TRAVERSE) ? ST_NOT_FOUND : ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            base_nxt  = base_r + POS_W'(WORD_BITS);
            first_nxt = 1'b0;
          end
        end
      end

      // hand result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({status_r, res_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      word_r       <= '0;
      out_valid_r  <= 1'b0;
      alloc_mask_r <= '1;
      index_max_r  <= '1;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ALLOC_MASK: alloc_mask_r <= cfg_wdata;
          REG_INDEX_MAX:  index_max_r  <= cfg_wdata;
          default:        ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    start_r    <= start_nxt;
    limit_r    <= limit_nxt;
    first_r    <= first_nxt;
    dv_r       <= dv_nxt;
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    bitv_r     <= bitv_nxt;
    div_num_r  <= div_num_nxt;
    div_rem_r  <= div_rem_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // bitmap storage
  bia_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_local_map (
    .clk   (clk),
    .we    (we_loc),
    .waddr (word_r),
    .wdata (wr_data),
    .raddr (word_r),
    .rdata (rd_loc)
  );

  bia_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_global_map (
    .clk   (clk),
    .we    (we_glob),
    .waddr (word_r),
    .wdata (wr_data),
    .raddr (word_r),
    .rdata (rd_glob)
  );

  bia_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_valid_map (
    .clk   (clk),
    .we    (we_val),
    .waddr (word_r),
    .wdata (wr_data),
    .raddr (word_r),
    .rdata (rd_val)
  );

endmodule

### hdl/bia_checker.sv
// Port-level checker for the bitmap index allocator, bound to the top level.
module bia_checker #(
  parameter int INDEX_BITS = bia_pkg::INDEX_BITS_DEF
) (
  input logic                                       clk,
  input logic                                       rst_n,
  input logic                                       in_tvalid,
  input logic                                       in_tready,
  input logic                                       out_tvalid,
  input logic                                       out_tready,
  input logic [bia_pkg::bytes_up(INDEX_BITS+2)-1:0] out_tdata
);
  import bia_pkg::*;

  // reset starts the clearing pass: nothing accepted, nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("output valid or input ready right after reset");

  // one item at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready in the cycle after an accepted transaction");

  // error results carry a zero index
  a_error_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[INDEX_BITS+1:INDEX_BITS] != ST_OK)
      |-> (out_tdata[INDEX_BITS-1:0] == '0))
    else $error("nonzero result index with an error status");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

endmodule

bind bitmap_index_allocator_top bia_checker #(.INDEX_BITS(INDEX_BITS)) u_bia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/tb_bitmap_index_allocator_top.sv
// Testbench for the bitmap index allocator: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb_bitmap_index_allocator_top;
  import bia_pkg::*;

  localparam int IDX_W       = INDEX_BITS_DEF;
  localparam int ENTRIES     = 1 << IDX_W;
  localparam int IN_W        = bytes_up(IDX_W + 3);
  localparam int OUT_W       = bytes_up(IDX_W + 2);
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic              absent;
    logic              bitv;
    logic              tstart;
  } alloc_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [STATUS_W-1:0] status;
  } alloc_resp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic [KIND_W-1:0]    in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0]     cfg_wdata = '0;

  // Predictor state
  bit               local_busy  [ENTRIES];
  bit               global_busy [ENTRIES];
  bit               valid_set   [ENTRIES];
  logic [IDX_W-1:0] alloc_mask = TOP_IDX;
  logic [IDX_W-1:0] index_max  = TOP_IDX;

  alloc_resp_t due_responses[$];
  int          err_cnt   = 0;
  bit          idle_en   = 1'b0;
  bit          hold_req  = 1'b0;
  logic [IDX_W-1:0] hot_base = '0;

  bitmap_index_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected response for one request; applies bit writes to the shadow maps
  function automatic alloc_resp_t compute_alloc_response(input alloc_req_t req);
    alloc_resp_t rsp;
    int          limit;
    int          pos;
    bit          hit;
    bit          busy;
    rsp.index  = '0;
    rsp.status = ST_OK;
    hit        = 1'b0;
    case (req.kind)
      KIND_WR_LOCAL: begin
        local_busy[req.index] = req.bitv;
        rsp.index = req.index;
      end
      KIND_WR_GLOBAL: begin
        global_busy[req.index] = req.bitv;
        rsp.index = req.index;
      end
      KIND_WR_VALID: begin
        valid_set[req.index] = req.bitv;
        rsp.index = req.index;
      end
      KIND_AL_LOCAL, KIND_AL_GLOBAL: begin
        if (req.absent) begin
          // free entry = valid and not busy in the selected map
          limit = int'((req.index & ~alloc_mask) | alloc_mask);
          pos   = int'(req.index);
          while (!hit && pos <= limit) begin
            busy = (req.kind == KIND_AL_GLOBAL) ? global_busy[pos] : local_busy[pos];
            if (valid_set[pos] && !busy) hit = 1'b1;
            else pos++;
          end
          if (hit) rsp.index = pos[IDX_W-1:0];
          else rsp.status = ST_FULL;
        end else if (req.index > index_max) begin
          rsp.status = ST_BEYOND;
        end else begin
          rsp.index = req.index;
        end
      end
      KIND_TRAVERSE: begin
        // start may run past the top entry; then nothing is found
        pos = int'(req.index) + (req.tstart ? 0 : 1);
        while (!hit && pos <= int'(index_max)) begin
          if (local_busy[pos]) hit = 1'b1;
          else pos++;
        end
        if (hit) rsp.index = pos[IDX_W-1:0];
        else rsp.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Random request, mostly inside the current hot window so searches hit
  function automatic alloc_req_t random_req();
    alloc_req_t req;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      req.kind = KIND_WR_VALID;
    else if (pick < 40) req.kind = KIND_WR_LOCAL;
    else if (pick < 50) req.kind = KIND_WR_GLOBAL;
    else if (pick < 70) req.kind = KIND_AL_LOCAL;
    else if (pick < 85) req.kind = KIND_AL_GLOBAL;
    else                req.kind = KIND_TRAVERSE;
    pick = $urandom_range(0, 99);
    if (pick < 70)      req.index = hot_base + IDX_W'($urandom_range(0, 63));
    else if (pick < 80) req.index = $urandom_range(0, 1) ? TOP_IDX : '0;
    else                req.index = IDX_W'($urandom);
    req.absent = ($urandom_range(0, 4) != 0);
    req.bitv   = ($urandom_range(0, 3) != 0);
    req.tstart = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // One transaction on the input channel; valid stays high on return
  task automatic send_req(input alloc_req_t req);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.kind;
    in_tdata  <= {1'b0, req.tstart, req.bitv, req.absent, req.index};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    due_responses.push_back(compute_alloc_response(req));
    @(posedge clk);
  endtask

  task automatic send_fields(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] index,
                             input logic absent, input logic bitv, input logic tstart);
    alloc_req_t req;
    req = '{kind: kind, index: index, absent: absent, bitv: bitv, tstart: tstart};
    send_req(req);
  endtask

  // Stop offering and let every outstanding response come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers, back to back; only called while the block is idle
  task automatic set_config(input logic [IDX_W-1:0] mask, input logic [IDX_W-1:0] maxv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALLOC_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= REG_INDEX_MAX;
    cfg_wdata <= maxv;
    @(posedge clk);
    cfg_we <= 1'b0;
    alloc_mask = mask;
    index_max  = maxv;
  endtask

  // Empty maps right after reset
  task automatic test_reset_state();
    send_fields(KIND_AL_LOCAL, '0, 1'b1, 1'b0, 1'b0);
    send_fields(KIND_TRAVERSE, '0, 1'b0, 1'b0, 1'b1);
    send_fields(KIND_AL_GLOBAL, TOP_IDX, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_bitmap_writes();
    send_fields(KIND_WR_VALID, '0, 1'b0, 1'b1, 1'b0);
    send_fields(KIND_WR_VALID, 12'd5, 1'b1, 1'b1, 1'b1);
    send_fields(KIND_WR_VALID, TOP_IDX, 1'b0, 1'b1, 1'b0);
    send_fields(KIND_WR_VALID, 12'd7, 1'b0, 1'b0, 1'b0);
    send_fields(KIND_WR_LOCAL, 12'd5, 1'b0, 1'b1, 1'b0);
    send_fields(KIND_WR_GLOBAL, '0, 1'b0, 1'b1, 1'b0);
    send_fields(KIND_WR_LOCAL, TOP_IDX, 1'b0, 1'b1, 1'b0);
  endtask

  // Free-entry search, full mask then a mask of zero (search only at start)
  task automatic test_alloc_search();
    send_fields(KIND_AL_LOCAL, '0, 1'b1, 1'b0, 1'b0);
    send_fields(KIND_AL_GLOBAL, '0, 1'b1, 1'b0, 1'b0);
    send_fields(KIND_AL_LOCAL, 12'd1, 1'b1, 1'b0, 1'b0);
    send_fields(KIND_AL_GLOBAL, TOP_IDX, 1'b1, 1'b0, 1'b0);
    drain();
    set_config('0, 12'd100);
    send_fields(KIND_AL_LOCAL, 12'd1, 1'b1, 1'b0, 1'b0);
    send_fields(KIND_AL_LOCAL, '0, 1'b1, 1'b0, 1'b0);
  endtask

  // Given index against the maximum; searches ignore the maximum
  task automatic test_alloc_check();
    send_fields(KIND_AL_LOCAL, 12'd100, 1'b0, 1'b0, 1'b0);
    send_fields(KIND_AL_LOCAL, 12'd101, 1'b0, 1'b0, 1'b0);
    send_fields(KIND_AL_GLOBAL, TOP_IDX, 1'b0, 1'b0, 1'b0);
    send_fields(KIND_AL_GLOBAL, TOP_IDX, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_traverse();
    drain();
    set_config(TOP_IDX, TOP_IDX);
    send_fields(KIND_TRAVERSE, 12'd5, 1'b0, 1'b0, 1'b1);
    send_fields(KIND_TRAVERSE, 12'd5, 1'b0, 1'b0, 1'b0);
    send_fields(KIND_TRAVERSE, TOP_IDX, 1'b0, 1'b0, 1'b0);
    send_fields(KIND_TRAVERSE, TOP_IDX, 1'b0, 1'b0, 1'b1);
    drain();
    set_config(TOP_IDX, 12'd100);
    send_fields(KIND_TRAVERSE, '0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int count, input logic [IDX_W-1:0] mask,
                                     input logic [IDX_W-1:0] maxv, input bit gaps);
    drain();
    set_config(mask, maxv);
    idle_en  = gaps;
    hot_base = IDX_W'($urandom_range(0, ENTRIES / 64 - 1) * 64);
    repeat (count) send_req(random_req());
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    drain();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    repeat (16) send_req(random_req());
  endtask

  // Result channel ready: random stalls, plus one long hold on request
  initial begin
    int  hold_cnt;
    int  stall_cnt;
    bit  rdy;
    bit  hold_done;
    hold_cnt  = 0;
    stall_cnt = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES - 1;
        rdy       = 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        rdy = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(1, 11) - 1;
        rdy       = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  // Response check; handshakes are sampled at the falling edge before they complete
  alloc_resp_t want;
  alloc_resp_t got;
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.index  = out_tdata[IDX_W-1:0];
      got.status = out_tdata[IDX_W +: STATUS_W];
      if (due_responses.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected response: index %0d status %0d", got.index, got.status);
      end else begin
        want = due_responses.pop_front();
        if (got.index !== want.index || got.status !== want.status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("response mismatch: expected index %0d status %0d, got index %0d status %0d",
                     want.index, want.status, got.index, got.status);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_bitmap_writes();
    test_alloc_search();
    test_alloc_check();
    test_traverse();
    test_random_traffic(200, TOP_IDX, TOP_IDX, 1'b1);
    test_random_traffic(120, '0, '0, 1'b1);
    test_backpressure();
    test_random_traffic(200, 12'h00F, 12'h7FF, 1'b1);
    test_random_traffic(180, IDX_W'($urandom), IDX_W'($urandom), 1'b1);
    test_random_traffic(200, 12'h03F, TOP_IDX, 1'b0);
    drain();
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bia_pkg.sv
hdl/bia_ram.sv
hdl/bitmap_index_allocator_top.sv
hdl/bia_checker.sv
test/tb_bitmap_index_allocator_top.sv
